FILE: hdl/csv_field_tokenizer_macros.svh
// Assertion macros shared by the CSV field tokenizer RTL.
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CSVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csv tokenizer assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CSVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csv tokenizer assertion failed");
`else
`define CSVT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/csvt_pkg.sv
// Types, codes and constants of the CSV field tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

    localparam int NULL_MAX_LEN    = 19;
    localparam int NULL_TEXT_BYTES = 19;
    localparam int NULL_TEXT_W     = NULL_TEXT_BYTES * 8;
    localparam int CNT_W           = $clog2(NULL_MAX_LEN + 2);
    localparam int MAX_RESULTS     = 3;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W       = $clog2(MAX_RESULTS);

    // Result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_QUOTE_CHAR     = 3'd0;
    localparam logic [2:0] REG_ESCAPE_CHAR    = 3'd1;
    localparam logic [2:0] REG_DELIMITER      = 3'd2;
    localparam logic [2:0] REG_NULL_LENGTH    = 3'd3;
    localparam logic [2:0] REG_NULL_TEXT_LOW  = 3'd4;
    localparam logic [2:0] REG_NULL_TEXT_MID  = 3'd5;
    localparam logic [2:0] REG_NULL_TEXT_HIGH = 3'd6;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam logic [7:0] QUOTE_RESET  = 8'h22;
    localparam logic [7:0] ESCAPE_RESET = 8'h22;
    localparam logic [7:0] DELIM_RESET  = 8'h2C;

    typedef struct packed {
        logic [7:0]             quote_char;
        logic [7:0]             escape_char;
        logic [7:0]             delimiter;
        logic [4:0]             null_length;
        logic [NULL_TEXT_W-1:0] null_text;
    } cfg_t;

    typedef struct packed {
        logic             in_quote;
        logic             escape_pending;
        logic             cr_pending;
        logic [CNT_W-1:0] raw_count;
        logic             raw_matches;
        logic [CNT_W-1:0] cooked_count;
        logic             cooked_matches;
        logic             saw_quote;
    } tok_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       null_f;
        logic       quoted;
    } tok_result_t;

    typedef struct packed {
        tok_state_t                         st;
        tok_result_t [MAX_RESULTS-1:0]      res;
        logic        [RES_CNT_W-1:0]        cnt;
    } tok_work_t;

endpackage

FILE: hdl/csv_field_tokenizer.sv
// CSV field tokenizer top level: one raw byte in, up to three tokens out.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_in_byte, s_end_of_input
//  m_       | out       | m_valid / m_ready  | m_out_kind, m_out_byte, m_field_null,
//           |           |                    | m_field_quoted, m_last_of_run
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wr_data (no read-back)
//
// Rate: one byte per cycle while each byte yields at most one token and m_ready does not
// stall the output; a byte with several tokens holds the item register for one output load
// per token. Path: s_ port, item register, output register, m_ port.
// Reset: synchronous, active low; parser state and configuration return to defaults.
// Stalls: s_ready follows output register space combinationally through m_ready.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_macros.svh"
module csv_field_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_input,
    // token channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_field_null,
    output logic        m_field_quoted,
    output logic        m_last_of_run,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data
);

    // ------------------------------------------------------------------
    // Token engine: the byte-level rules as pure functions
    // ------------------------------------------------------------------

    // Advance a null-string matcher by one byte; the count saturates one past the limit.
    function automatic logic [csvt_pkg::CNT_W:0] f_track(
        input logic [csvt_pkg::CNT_W-1:0] cnt,
        input logic                       match,
        input logic [7:0]                 b,
        input csvt_pkg::cfg_t             cfg
    );
        logic [7:0]                 nb;
        logic [csvt_pkg::CNT_W-1:0] c;
        logic                       m;
        nb = (cnt < csvt_pkg::CNT_W'(csvt_pkg::NULL_TEXT_BYTES)) ?
             cfg.null_text[{cnt, 3'b000} +: 8] : 8'h00;
        c  = cnt;
        m  = match;
        if (cnt >= cfg.null_length || cnt >= csvt_pkg::CNT_W'(csvt_pkg::NULL_MAX_LEN) ||
            nb != b) begin
            m = 1'b0;
        end
        if (cnt < csvt_pkg::CNT_W'(csvt_pkg::NULL_MAX_LEN + 1)) begin
            c = cnt + 1'b1;
        end
        return {c, m};
    endfunction

    // Append a token; tokens past the third are dropped, state still advances.
    function automatic csvt_pkg::tok_work_t f_emit(
        input csvt_pkg::tok_work_t w,
        input logic [1:0]          kind,
        input logic [7:0]          b,
        input logic                nul,
        input logic                quo
    );
        csvt_pkg::tok_work_t r;
        r = w;
        if (w.cnt < csvt_pkg::RES_CNT_W'(csvt_pkg::MAX_RESULTS)) begin
            r.res[w.cnt[csvt_pkg::RES_IDX_W-1:0]] = '{kind: kind, data: b,
                                                      null_f: nul, quoted: quo};
            r.cnt = w.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic csvt_pkg::tok_work_t f_cooked_data(
        input csvt_pkg::tok_work_t w,
        input logic [7:0]          b,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        r = w;
        {r.st.cooked_count, r.st.cooked_matches} =
            f_track(w.st.cooked_count, w.st.cooked_matches, b, cfg);
        r = f_emit(r, csvt_pkg::KIND_DATA, b, 1'b0, 1'b0);
        return r;
    endfunction

    // Release a held carriage return as data.
    function automatic csvt_pkg::tok_work_t f_flush_cr(
        input csvt_pkg::tok_work_t w,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        r = w;
        if (w.st.cr_pending) begin
            r.st.cr_pending = 1'b0;
            r = f_cooked_data(r, csvt_pkg::BYTE_CR, cfg);
        end
        return r;
    endfunction

    // Deliver one unescaped byte; hold a carriage return until its fate is known.
    function automatic csvt_pkg::tok_work_t f_cook(
        input csvt_pkg::tok_work_t w,
        input logic [7:0]          b,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        r = f_flush_cr(w, cfg);
        if (b == csvt_pkg::BYTE_CR) begin
            r.st.cr_pending = 1'b1;
        end else begin
            r = f_cooked_data(r, b, cfg);
        end
        return r;
    endfunction

    function automatic csvt_pkg::tok_work_t f_end_field(
        input csvt_pkg::tok_work_t w,
        input logic                row,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        logic                nul;
        r   = w;
        nul = w.st.raw_matches && (w.st.raw_count == csvt_pkg::CNT_W'(cfg.null_length));
        if (row) begin
            // drop a trailing carriage return and retest null on the cooked bytes
            if (!nul && w.st.cr_pending) begin
                nul = w.st.cooked_matches &&
                      (w.st.cooked_count == csvt_pkg::CNT_W'(cfg.null_length));
            end
            r.st.cr_pending = 1'b0;
        end else begin
            r = f_flush_cr(r, cfg);
        end
        r = f_emit(r, row ? csvt_pkg::KIND_ROW_END : csvt_pkg::KIND_FIELD_END, 8'h00,
                   nul, w.st.saw_quote);
        r.st.raw_count      = '0;
        r.st.raw_matches    = 1'b1;
        r.st.cooked_count   = '0;
        r.st.cooked_matches = 1'b1;
        r.st.saw_quote      = 1'b0;
        return r;
    endfunction

    function automatic csvt_pkg::tok_work_t f_plain(
        input csvt_pkg::tok_work_t w,
        input logic [7:0]          b,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        r = w;
        if (!w.st.in_quote) begin
            if (b == cfg.delimiter || b == csvt_pkg::BYTE_LF) begin
                r = f_end_field(r, b == csvt_pkg::BYTE_LF, cfg);
            end else begin
                {r.st.raw_count, r.st.raw_matches} =
                    f_track(w.st.raw_count, w.st.raw_matches, b, cfg);
                if (b == cfg.quote_char) begin
                    r.st.in_quote  = 1'b1;
                    r.st.saw_quote = 1'b1;
                end else begin
                    r = f_cook(r, b, cfg);
                end
            end
        end else begin
            {r.st.raw_count, r.st.raw_matches} =
                f_track(w.st.raw_count, w.st.raw_matches, b, cfg);
            if (b == cfg.escape_char) begin
                r.st.escape_pending = 1'b1;
            end else if (b == cfg.quote_char) begin
                r.st.in_quote = 1'b0;
            end else begin
                r = f_cook(r, b, cfg);
            end
        end
        return r;
    endfunction

    function automatic csvt_pkg::tok_work_t f_take(
        input csvt_pkg::tok_work_t w,
        input logic [7:0]          b,
        input csvt_pkg::cfg_t      cfg
    );
        csvt_pkg::tok_work_t r;
        logic                done;
        r    = w;
        done = 1'b0;
        if (w.st.escape_pending) begin
            r.st.escape_pending = 1'b0;
            if (b == cfg.quote_char || b == cfg.escape_char) begin
                {r.st.raw_count, r.st.raw_matches} =
                    f_track(w.st.raw_count, w.st.raw_matches, b, cfg);
                r    = f_cook(r, b, cfg);
                done = 1'b1;
            end else if (cfg.escape_char == cfg.quote_char) begin
                r.st.in_quote = 1'b0;
            end else begin
                r = f_cook(r, cfg.escape_char, cfg);
            end
        end
        if (!done) begin
            r = f_plain(r, b, cfg);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    csvt_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quote_char  <= csvt_pkg::QUOTE_RESET;
            cfg_reg.escape_char <= csvt_pkg::ESCAPE_RESET;
            cfg_reg.delimiter   <= csvt_pkg::DELIM_RESET;
            cfg_reg.null_length <= '0;
            cfg_reg.null_text   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                csvt_pkg::REG_QUOTE_CHAR:     cfg_reg.quote_char      <= cfg_wr_data[7:0];
                csvt_pkg::REG_ESCAPE_CHAR:    cfg_reg.escape_char     <= cfg_wr_data[7:0];
                csvt_pkg::REG_DELIMITER:      cfg_reg.delimiter       <= cfg_wr_data[7:0];
                csvt_pkg::REG_NULL_LENGTH:    cfg_reg.null_length     <= cfg_wr_data[4:0];
                csvt_pkg::REG_NULL_TEXT_LOW:  cfg_reg.null_text[63:0]   <= cfg_wr_data;
                csvt_pkg::REG_NULL_TEXT_MID:  cfg_reg.null_text[127:64] <= cfg_wr_data;
                csvt_pkg::REG_NULL_TEXT_HIGH: cfg_reg.null_text[151:128] <= cfg_wr_data[23:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item register, parser state and drain index
    // ------------------------------------------------------------------
    logic                              item_valid_reg;
    logic [7:0]                        item_byte_reg;
    logic                              item_eoi_reg;
    csvt_pkg::tok_state_t              state_reg;
    logic [csvt_pkg::RES_IDX_W-1:0]    idx_reg;
    logic [csvt_pkg::RES_IDX_W-1:0]    idx_next;

    logic                              m_valid_reg;
    csvt_pkg::tok_result_t             m_res_reg;
    logic                              m_last_reg;

    csvt_pkg::tok_work_t               work;
    csvt_pkg::tok_work_t               work_first;
    csvt_pkg::tok_work_t               work_start;
    logic                              out_free;
    logic                              load_out;
    logic                              last_sel;
    logic                              consume;
    logic                              s_accept;

    // Evaluate the held byte against the committed state; at end of input a non-newline byte
    // gets an implied newline as second pass unless it would only land inside an open quote.
    always_comb begin
        work_start     = '0;
        work_start.st  = state_reg;
        work_first     = f_take(work_start, item_byte_reg, cfg_reg);
        work           = work_first;
        if (item_eoi_reg && item_byte_reg != csvt_pkg::BYTE_LF &&
            (!work_first.st.in_quote ||
             (work_first.st.escape_pending && cfg_reg.escape_char == cfg_reg.quote_char)))
        begin
            work = f_take(work_first, csvt_pkg::BYTE_LF, cfg_reg);
        end
    end

    // Hand out tokens one per output load; commit the state with the final token, or at
    // once when the byte produces none.
    assign out_free = !m_valid_reg || m_ready;
    assign last_sel = (csvt_pkg::RES_CNT_W'(idx_reg) + 1'b1) == work.cnt;
    assign load_out = item_valid_reg && (work.cnt != '0) && out_free;
    assign consume  = item_valid_reg && ((work.cnt == '0) || (out_free && last_sel));
    assign s_ready  = !item_valid_reg || consume;
    assign s_accept = s_valid && s_ready;
    assign idx_next = consume ? '0 : (load_out ? idx_reg + 1'b1 : idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg           <= 1'b0;
            idx_reg                  <= '0;
            state_reg.in_quote       <= 1'b0;
            state_reg.escape_pending <= 1'b0;
            state_reg.cr_pending     <= 1'b0;
            state_reg.raw_count      <= '0;
            state_reg.raw_matches    <= 1'b1;
            state_reg.cooked_count   <= '0;
            state_reg.cooked_matches <= 1'b1;
            state_reg.saw_quote      <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (s_accept) begin
                item_valid_reg <= 1'b1;
            end else if (consume) begin
                item_valid_reg <= 1'b0;
            end
            if (consume) begin
                state_reg <= work.st;
            end
        end
    end

    // Item payload: load on acceptance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_byte_reg <= s_in_byte;
            item_eoi_reg  <= s_end_of_input;
        end
    end

    // Output register: advance on load, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_res_reg  <= work.res[idx_reg];
            m_last_reg <= last_sel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_kind     = m_res_reg.kind;
    assign m_out_byte     = m_res_reg.data;
    assign m_field_null   = m_res_reg.null_f;
    assign m_field_quoted = m_res_reg.quoted;
    assign m_last_of_run  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a partly drained byte always has its item still held
    `CSVT_ASSERT_NOW(a_idx_needs_item, aclk, aresetn, idx_reg != '0, item_valid_reg)
    // the token that retires a byte is flagged as the last of its run
    `CSVT_ASSERT_NEXT(a_retire_marks_last, aclk, aresetn, consume && work.cnt != '0,
        m_valid_reg && m_last_reg)
    // parser state holds while a byte's tokens are still draining
    `CSVT_ASSERT_NEXT(a_state_holds, aclk, aresetn, item_valid_reg && !consume,
        $stable(state_reg))
    // data tokens never carry field flags
    `CSVT_ASSERT_NOW(a_data_no_flags, aclk, aresetn,
        m_valid_reg && m_res_reg.kind == csvt_pkg::KIND_DATA,
        !m_res_reg.null_f && !m_res_reg.quoted)

endmodule

FILE: sim/csv_field_tokenizer_tb.sv
// Self-checking testbench for the CSV field tokenizer: random CSV rows, stalls and settings.
`timescale 1ns / 1ps
module csv_field_tokenizer_tb;

    // Allowed run of cycles with no transaction on either channel and no register write.
    localparam int QUIET_LIMIT = 1000;
    // Length of the long receiver hold-off.
    localparam int PARK_CYCLES = 60;

    // One token as it leaves the m_ channel.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       nul;
        logic       quoted;
        logic       last;
    } token_t;

    // One raw byte waiting to be offered, with the idle cycles to insert ahead of it.
    typedef struct {
        logic [7:0]  data;
        logic        eoi;
        int unsigned gap;
    } byte_item_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte      = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic        m_field_null;
    logic        m_field_quoted;
    logic        m_last_of_run;
    logic        cfg_wr_en      = 1'b0;
    logic [2:0]  cfg_index      = csvt_pkg::REG_QUOTE_CHAR;
    logic [63:0] cfg_wr_data    = 64'h0;

    csv_field_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_field_null   (m_field_null),
        .m_field_quoted (m_field_quoted),
        .m_last_of_run  (m_last_of_run),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Tokenizer prediction: our own copy of the register values and parser state.
    // ------------------------------------------------------------------
    logic [7:0]  quote_b  = csvt_pkg::QUOTE_RESET;
    logic [7:0]  escape_b = csvt_pkg::ESCAPE_RESET;
    logic [7:0]  delim_b  = csvt_pkg::DELIM_RESET;
    logic [4:0]  null_len = 5'd0;
    logic [63:0] null_lo  = 64'h0;
    logic [63:0] null_mid = 64'h0;
    logic [23:0] null_hi  = 24'h0;

    bit          in_quotes       = 1'b0;
    bit          esc_armed       = 1'b0;
    bit          cr_held         = 1'b0;
    bit          raw_same        = 1'b1;
    bit          cooked_same     = 1'b1;
    bit          field_had_quote = 1'b0;
    int unsigned raw_len         = 0;
    int unsigned cooked_len      = 0;

    token_t byte_tokens[$];   // tokens raised by the byte being tokenized
    token_t tokens_due[$];    // tokens predicted but not yet seen on m_

    // True when byte idx of the null string exists and equals b.
    function automatic bit null_byte_is(int unsigned idx, logic [7:0] b);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 8)       c = null_lo[8*idx +: 8];
        else if (idx < 16) c = null_mid[8*(idx-8) +: 8];
        else if (idx < 19) c = null_hi[8*(idx-16) +: 8];
        return (idx < null_len) && (idx < csvt_pkg::NULL_MAX_LEN) && (c == b);
    endfunction

    task automatic note_raw(logic [7:0] b);
        if (!null_byte_is(raw_len, b)) raw_same = 1'b0;
        if (raw_len < csvt_pkg::NULL_MAX_LEN + 1) raw_len++;
    endtask

    task automatic note_cooked(logic [7:0] b);
        if (!null_byte_is(cooked_len, b)) cooked_same = 1'b0;
        if (cooked_len < csvt_pkg::NULL_MAX_LEN + 1) cooked_len++;
    endtask

    // Raise one token; a byte never raises more than MAX_RESULTS.
    task automatic put_token(logic [1:0] kind, logic [7:0] b, bit nul, bit quo);
        token_t t;
        if (byte_tokens.size() >= csvt_pkg::MAX_RESULTS) return;
        t = '{kind, b, nul, quo, 1'b0};
        byte_tokens.push_back(t);
    endtask

    // Emit a held carriage return as data.
    task automatic release_cr();
        if (cr_held) begin
            cr_held = 1'b0;
            note_cooked(csvt_pkg::BYTE_CR);
            put_token(csvt_pkg::KIND_DATA, csvt_pkg::BYTE_CR, 1'b0, 1'b0);
        end
    endtask

    // Pass one unescaped byte toward the output; hold a carriage return back.
    task automatic cook_byte(logic [7:0] b);
        release_cr();
        if (b == csvt_pkg::BYTE_CR) begin
            cr_held = 1'b1;
        end else begin
            note_cooked(b);
            put_token(csvt_pkg::KIND_DATA, b, 1'b0, 1'b0);
        end
    endtask

    // Close the field; at end of row drop a held carriage return and retest null on cooked bytes.
    task automatic close_field(bit row);
        bit nul;
        nul = raw_same && (raw_len == null_len);
        if (row) begin
            if (!nul && cr_held) nul = cooked_same && (cooked_len == null_len);
            cr_held = 1'b0;
        end else begin
            release_cr();
        end
        put_token(row ? csvt_pkg::KIND_ROW_END : csvt_pkg::KIND_FIELD_END, 8'h00, nul,
                  field_had_quote);
        raw_len         = 0;
        raw_same        = 1'b1;
        cooked_len      = 0;
        cooked_same     = 1'b1;
        field_had_quote = 1'b0;
    endtask

    task automatic scan_byte(logic [7:0] b);
        if (esc_armed) begin
            esc_armed = 1'b0;
            if (b == quote_b || b == escape_b) begin
                note_raw(b);
                cook_byte(b);
                return;
            end
            // escape not followed by quote or escape: closes the quote or stands literally
            if (escape_b == quote_b) in_quotes = 1'b0;
            else cook_byte(escape_b);
        end
        if (!in_quotes) begin
            // delimiter and newline win over the quote outside quotes
            if (b == delim_b || b == csvt_pkg::BYTE_LF) begin
                close_field(b == csvt_pkg::BYTE_LF);
                return;
            end
            note_raw(b);
            if (b == quote_b) begin
                in_quotes       = 1'b1;
                field_had_quote = 1'b1;
            end else begin
                cook_byte(b);
            end
        end else begin
            // inside quotes the escape wins over the quote
            note_raw(b);
            if (b == escape_b)     esc_armed = 1'b1;
            else if (b == quote_b) in_quotes = 1'b0;
            else                   cook_byte(b);
        end
    endtask

    int unsigned triple_bytes = 0;

    // Predict every token that one accepted byte raises and queue them in order.
    task automatic tokenize_byte(logic [7:0] b, logic eoi);
        token_t t;
        byte_tokens.delete();
        scan_byte(b);
        // end of input implies a newline unless it would only land as quoted data
        if (eoi && b != csvt_pkg::BYTE_LF &&
            (!in_quotes || (esc_armed && escape_b == quote_b)))
            scan_byte(csvt_pkg::BYTE_LF);
        if (byte_tokens.size() == csvt_pkg::MAX_RESULTS) triple_bytes++;
        if (byte_tokens.size() != 0) begin
            t      = byte_tokens.pop_back();
            t.last = 1'b1;
            byte_tokens.push_back(t);
        end
        while (byte_tokens.size() != 0) tokens_due.push_back(byte_tokens.pop_front());
    endtask

    // ------------------------------------------------------------------
    // Shared controls, written by the stimulus process at falling edges only.
    // ------------------------------------------------------------------
    byte_item_t  send_q[$];
    bit          sender_calm = 1'b0;   // draw zero gaps for newly queued bytes
    bit          reader_calm = 1'b0;   // draw zero stalls after each token
    bit          hold_sender = 1'b0;   // stop offering new bytes
    int unsigned park_req    = 0;      // bump to ask for one long receiver hold-off

    // ------------------------------------------------------------------
    // Byte driver: offer queued bytes, predict on each accepted transaction.
    // ------------------------------------------------------------------
    int unsigned bytes_sent = 0;
    int unsigned lead_cnt   = 0;

    always @(posedge aclk) begin
        byte_item_t it;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            lead_cnt = 0;
        end else begin
            if (s_valid && s_ready) begin
                tokenize_byte(s_in_byte, s_end_of_input);
                bytes_sent++;
            end
            // the slot is free when nothing is offered or the offer was just taken
            if (!s_valid || s_ready) begin
                if (send_q.size() == 0 || hold_sender) begin
                    s_valid <= 1'b0;
                end else if (lead_cnt < send_q[0].gap) begin
                    lead_cnt++;
                    s_valid <= 1'b0;
                end else begin
                    it       = send_q.pop_front();
                    lead_cnt = 0;
                    s_valid        <= 1'b1;
                    s_in_byte      <= it.data;
                    s_end_of_input <= it.eoi;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Token monitor: stall at random, compare each token with the oldest prediction.
    // ------------------------------------------------------------------
    int unsigned mismatches     = 0;
    int unsigned tokens_checked = 0;
    int unsigned rows_seen      = 0;
    int unsigned nulls_seen     = 0;
    int unsigned quoted_seen    = 0;
    int unsigned park_seen      = 0;
    int unsigned park_left      = 0;
    int unsigned stall_left     = 0;

    function automatic string show(token_t t);
        return $sformatf("kind %0d byte %02h null %b quoted %b last %b",
                         t.kind, t.data, t.nul, t.quoted, t.last);
    endfunction

    always @(posedge aclk) begin
        token_t want, got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (park_req != park_seen) begin
                park_seen = park_req;
                park_left = PARK_CYCLES;
            end
            if (m_valid && m_ready) begin
                got = '{m_out_kind, m_out_byte, m_field_null, m_field_quoted, m_last_of_run};
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("token with nothing predicted: %s", show(got));
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("token %0d mismatch: expected %s, got %s",
                                     tokens_checked, show(want), show(got));
                    end
                    tokens_checked++;
                    if (want.kind == csvt_pkg::KIND_ROW_END) rows_seen++;
                    if (want.kind != csvt_pkg::KIND_DATA && want.nul) nulls_seen++;
                    if (want.kind != csvt_pkg::KIND_DATA && want.quoted) quoted_seen++;
                end
                stall_left = reader_calm ? 0 : $urandom_range(0, 7);
            end else if (park_left > 0) begin
                park_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (park_left == 0) && (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d tokens outstanding",
                     quiet_cycles, tokens_due.size());
            $display("csv_field_tokenizer_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: rows are built in row_buf, then handed to the driver queue.
    // ------------------------------------------------------------------
    byte_item_t  row_buf[$];
    int unsigned bytes_planned = 0;

    task automatic add_byte(logic [7:0] b, logic eoi = 1'b0);
        byte_item_t it;
        it.data = b;
        it.eoi  = eoi;
        it.gap  = sender_calm ? 0 : $urandom_range(0, 7);
        row_buf.push_back(it);
    endtask

    // Move the built row to the driver; optionally flag its last byte as end of input.
    task automatic send_row(bit eoi_tail);
        byte_item_t it;
        if (eoi_tail && row_buf.size() == 0) add_byte(csvt_pkg::BYTE_LF);
        while (row_buf.size() != 0) begin
            it = row_buf.pop_front();
            if (eoi_tail && row_buf.size() == 0) it.eoi = 1'b1;
            send_q.push_back(it);
            bytes_planned++;
        end
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] null_text_byte(int unsigned i);
        if (i < 8)  return null_lo[8*i +: 8];
        if (i < 16) return null_mid[8*(i-8) +: 8];
        if (i < 19) return null_hi[8*(i-16) +: 8];
        return 8'h00;
    endfunction

    task automatic add_field(int unsigned style);
        int unsigned n;
        case (style) inside
            0, 1, 2: begin
                n = $urandom_range(0, 5);
                repeat (n) add_byte(text_byte());
            end
            3, 4, 5: begin
                // quoted body with escaped quotes, escaped escapes, stray escapes,
                // embedded delimiters, newlines and carriage returns
                add_byte(quote_b);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0: begin add_byte(escape_b); add_byte(quote_b); end
                        1: begin add_byte(escape_b); add_byte(escape_b); end
                        2: begin add_byte(escape_b); add_byte(text_byte()); end
                        3: add_byte(delim_b);
                        4: add_byte(csvt_pkg::BYTE_LF);
                        5: add_byte(csvt_pkg::BYTE_CR);
                        default: add_byte(text_byte());
                    endcase
                end
                add_byte(quote_b);
            end
            6: begin
                for (int i = 0; i < null_len && i < 19; i++) add_byte(null_text_byte(i));
            end
            7: begin
                // null text wrapped in quotes, then a carriage return: only the
                // cooked bytes can match, and only at end of row
                add_byte(quote_b);
                for (int i = 0; i < null_len && i < 19; i++) add_byte(null_text_byte(i));
                add_byte(quote_b);
                add_byte(csvt_pkg::BYTE_CR);
            end
            default: begin
                // longer than the saturating counters
                n = $urandom_range(20, 24);
                repeat (n) add_byte(text_byte());
            end
        endcase
        if ($urandom_range(0, 5) == 0) add_byte(csvt_pkg::BYTE_CR);
    endtask

    task automatic make_row();
        int unsigned n;
        int unsigned tail;
        n = $urandom_range(1, 4);
        for (int f = 0; f < n; f++) begin
            if (f != 0) add_byte(delim_b);
            add_field($urandom_range(0, 8));
        end
        tail = $urandom_range(0, 5);
        case (tail)
            3:       begin add_byte(csvt_pkg::BYTE_CR); add_byte(csvt_pkg::BYTE_LF); end
            4:       ;
            5:       add_byte(csvt_pkg::BYTE_LF, 1'b1);
            default: add_byte(csvt_pkg::BYTE_LF);
        endcase
        send_row(tail == 4);
    endtask

    // Queue mostly well-formed rows, with some bursts of raw noise.
    task automatic queue_random(int unsigned budget);
        int unsigned stop_at;
        stop_at = bytes_planned + budget;
        while (bytes_planned < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                send_row(1'b0);
            end else begin
                make_row();
            end
        end
    endtask

    // Wait until every byte is taken and every token seen, then let the pipeline settle:
    // a byte that raises no token may still be inside the block.
    task automatic wait_drained();
        do @(negedge aclk); while (send_q.size() != 0 || s_valid || tokens_due.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            csvt_pkg::REG_QUOTE_CHAR:     quote_b  = val[7:0];
            csvt_pkg::REG_ESCAPE_CHAR:    escape_b = val[7:0];
            csvt_pkg::REG_DELIMITER:      delim_b  = val[7:0];
            csvt_pkg::REG_NULL_LENGTH:    null_len = val[4:0];
            csvt_pkg::REG_NULL_TEXT_LOW:  null_lo  = val;
            csvt_pkg::REG_NULL_TEXT_MID:  null_mid = val;
            csvt_pkg::REG_NULL_TEXT_HIGH: null_hi  = val[23:0];
            default: ;
        endcase
    endtask

    // Write the full register set while the block is idle.
    task automatic configure(logic [7:0] q, logic [7:0] e, logic [7:0] d, logic [4:0] len,
                             logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
        write_reg(csvt_pkg::REG_QUOTE_CHAR, {56'h0, q});
        write_reg(csvt_pkg::REG_ESCAPE_CHAR, {56'h0, e});
        write_reg(csvt_pkg::REG_DELIMITER, {56'h0, d});
        write_reg(csvt_pkg::REG_NULL_LENGTH, {59'h0, len});
        write_reg(csvt_pkg::REG_NULL_TEXT_LOW, lo);
        write_reg(csvt_pkg::REG_NULL_TEXT_MID, mid);
        write_reg(csvt_pkg::REG_NULL_TEXT_HIGH, hi);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [151:0] txt;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under reset settings: quote and escape are both '"', delimiter ',',
        // empty null string.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(delim_b);
        add_byte(quote_b);                  // open quote
        add_byte(quote_b);                  // doubled quote yields one quote
        add_byte(quote_b);
        add_byte(delim_b);                  // delimiter inside quotes is data
        add_byte(quote_b);
        add_byte(delim_b);                  // quote then delimiter closes the quoted field
        add_byte("x");
        add_byte(csvt_pkg::BYTE_CR);
        add_byte(csvt_pkg::BYTE_CR);        // first CR flushed, second held
        add_byte("y");
        add_byte(csvt_pkg::BYTE_CR);
        add_byte(csvt_pkg::BYTE_LF);        // held CR dropped at end of row
        add_byte(csvt_pkg::BYTE_CR);
        add_byte(delim_b);                  // held CR flushed before field end
        add_byte(csvt_pkg::BYTE_CR);
        add_byte(csvt_pkg::BYTE_LF);        // CR-only last field is null on cooked bytes
        add_byte(quote_b);
        add_byte("z", 1'b1);                // end of input inside quotes: row stays open
        add_byte(quote_b);
        add_byte("q", 1'b1);                // escape closes quote, implied newline ends row
        add_byte(csvt_pkg::BYTE_CR);
        add_byte("w", 1'b1);                // three tokens from one byte
        add_byte(quote_b);
        add_byte(quote_b, 1'b1);            // pending escape: implied newline closes the row
        add_byte(csvt_pkg::BYTE_LF, 1'b1);  // newline with end of input adds nothing
        send_row(1'b0);
        wait_drained();

        // Extremes: high quote, low escape colliding with delimiter, full-length null text.
        for (int i = 0; i < 19; i++) txt[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
        configure(8'hFF, 8'h01, 8'h01, 5'd19, txt[63:0], txt[127:64], {40'h0, txt[151:128]});
        queue_random(45);
        wait_drained();

        // Backslash escapes, two-byte null text; long receiver hold-off while the sender
        // streams, then a sender pause until every token has come back.
        configure(8'h27, 8'h5C, 8'h3B, 5'd2, 64'h4E5C, 64'h0, 64'h0);
        sender_calm = 1'b1;
        reader_calm = 1'b1;
        queue_random(30);
        park_req++;
        do @(negedge aclk); while (send_q.size() > 4);
        hold_sender = 1'b1;
        do @(negedge aclk); while (s_valid || tokens_due.size() != 0);
        hold_sender = 1'b0;
        sender_calm = 1'b0;
        reader_calm = 1'b0;
        queue_random(30);
        wait_drained();

        // Low quote, newline as escape, high delimiter, null length past the limit.
        configure(8'h01, csvt_pkg::BYTE_LF, 8'hFF, 5'd31, '1, '1, 64'hFFFFFF);
        reader_calm = 1'b1;
        queue_random(40);
        wait_drained();

        // Doubled-quote escaping with tab delimiter; a quoted empty field is the null text.
        configure(8'h22, 8'h22, 8'h09, 5'd2, 64'h2222, 64'h0, 64'h0);
        reader_calm = 1'b0;
        queue_random(40);
        wait_drained();

        // Quote equal to delimiter: the delimiter wins outside quotes. No idling at all.
        configure(8'h2C, 8'h5C, 8'h2C, 5'd0, 64'h0, 64'h0, 64'h0);
        sender_calm = 1'b1;
        reader_calm = 1'b1;
        queue_random(20);
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d bytes under 6 register sets; %0d tokens checked:",
                 bytes_sent, tokens_checked);
        $display("%0d rows, %0d null, %0d quoted; %0d bytes raised three tokens",
                 rows_seen, nulls_seen, quoted_seen, triple_bytes);
        $display("%0d mismatches, %0d tokens left over", mismatches, tokens_due.size());
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("csv_field_tokenizer_tb: done, clean");
        end else begin
            $display("csv_field_tokenizer_tb: done, errors");
        end
        $finish;
    end

endmodule
